// ----- src/lrps_pkg.sv -----
// ----------------------------------------------------------------------------
// lrps_pkg
// shared types and constants of the lpc prediction filter
// ----------------------------------------------------------------------------
package lrps_pkg;

  localparam int ACC_W     = 32;
  localparam int ORDER_W   = 6;
  localparam int SHIFT_W   = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 6;
  localparam int TAP_W     = 7;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT = 2'd2;

  // beat kinds
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // filter modes
  localparam logic MODE_ANALYSIS  = 1'b0;
  localparam logic MODE_SYNTHESIS = 1'b1;

  typedef struct packed {
    logic clear;
    logic rotate;
    logic insert;
  } cell_ctrl_t;

  typedef struct packed {
    logic init;
    logic run;
    logic tap_en;
  } mac_ctrl_t;

endpackage

// ----- src/lrps_cell.sv -----
// ----------------------------------------------------------------------------
// lrps_cell
// one filter tap: holds a history word and its coefficient
// ----------------------------------------------------------------------------
module lrps_cell #(
  parameter int COEF_BITS = 16,
  parameter int DATA_BITS = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lrps_pkg::cell_ctrl_t     ctrl_i,
  input  logic                     load_i,
  input  logic [COEF_BITS-1:0]     load_coef_i,
  input  logic [DATA_BITS-1:0]     rot_hist_i,
  input  logic [COEF_BITS-1:0]     rot_coef_i,
  input  logic [DATA_BITS-1:0]     ins_hist_i,
  output logic [DATA_BITS-1:0]     hist_o,
  output logic [COEF_BITS-1:0]     coef_o
);

  logic [DATA_BITS-1:0] hist_q, hist_d;
  logic [COEF_BITS-1:0] coef_q, coef_d;

  always_comb begin
    hist_d = hist_q;
    if (ctrl_i.clear) begin
      hist_d = '0;
    end else if (ctrl_i.rotate) begin
      hist_d = rot_hist_i;
    end else if (ctrl_i.insert) begin
      hist_d = ins_hist_i;
    end
  end

  always_comb begin
    coef_d = coef_q;
    if (load_i) begin
      coef_d = load_coef_i;
    end else if (ctrl_i.rotate) begin
      coef_d = rot_coef_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
    end else begin
      hist_q <= hist_d;
    end
  end

  // coefficient store is undefined until written
  always_ff @(posedge clk_i) begin
    coef_q <= coef_d;
  end

  assign hist_o = hist_q;
  assign coef_o = coef_q;

endmodule

// ----- src/lrps_mac.sv -----
// ----------------------------------------------------------------------------
// lrps_mac
// serial multiply-accumulate fed from the head cell of the chain
// ----------------------------------------------------------------------------
module lrps_mac #(
  parameter int COEF_BITS = 16,
  parameter int DATA_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lrps_pkg::mac_ctrl_t           ctrl_i,
  input  logic [lrps_pkg::SHIFT_W-1:0]  shift_i,
  input  logic [COEF_BITS-1:0]          coef_i,
  input  logic [DATA_BITS-1:0]          hist_i,
  output logic [lrps_pkg::ACC_W-1:0]    acc_o
);

  localparam int PROD_W = COEF_BITS + DATA_BITS;
  localparam int ACC_W  = lrps_pkg::ACC_W;
  localparam logic [lrps_pkg::SHIFT_W-1:0] SHIFT_ONE = 1;

  logic signed [PROD_W-1:0]       prod_d, prod_q;
  logic [ACC_W-1:0]               prod_acc;
  logic                           use_q;
  logic [ACC_W-1:0]               acc_q, acc_d, round;

  assign prod_d   = $signed(coef_i) * $signed(hist_i);
  assign prod_acc = ACC_W'(prod_q);

  always_comb begin
    if (shift_i == '0) begin
      round = '0;
    end else begin
      round = ACC_W'(1) << (shift_i - SHIFT_ONE);
    end
  end

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.init) begin
      acc_d = round;
    end else if (ctrl_i.run && use_q) begin
      acc_d = acc_q + prod_acc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_q <= 1'b0;
    end else if (ctrl_i.init) begin
      use_q <= 1'b0;
    end else if (ctrl_i.run) begin
      use_q <= ctrl_i.tap_en;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

// ----- src/lpc_residual_predict_synthesize.sv -----
// ----------------------------------------------------------------------------
// lpc_residual_predict_synthesize
// fixed-point lpc filter: residual analysis or sample synthesis
// ----------------------------------------------------------------------------
// a coefficient load beat returns nothing
// a sample result follows one full turn of the tap chain past a single multiplier,
// then the drain and finish steps; finish waits while an older result is stalled
// the input reopens with the result, so no new sample is taken while one is in work
// a sample can be accepted while the previous result still waits on the output
// reset clears the history, the registers and the handshake; coefficients stay undefined
// ----------------------------------------------------------------------------
module lpc_residual_predict_synthesize #(
  parameter int N_TAPS    = 32,
  parameter int COEF_BITS = 16,
  parameter int DATA_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lrps_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [lrps_pkg::CFG_DAT_W-1:0]   cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // coef_index[4:0], coef_value[20:5], sample[52:21], zero[55:53]
  input  logic [55:0]                      s_axis_tdata,
  // op[0], block_start[1]
  input  logic [1:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // out_value[31:0]
  output logic [31:0]                      m_axis_tdata
);

  localparam int ACC_W = lrps_pkg::ACC_W;
  localparam int CNT_W = (N_TAPS > 1) ? $clog2(N_TAPS) : 1;
  localparam logic [CNT_W-1:0]            CNT_LAST = CNT_W'(N_TAPS - 1);
  localparam logic [lrps_pkg::TAP_W-1:0]  TAP_MAX  = lrps_pkg::TAP_W'(N_TAPS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  state_e                          state_q;
  logic [CNT_W-1:0]                cnt_q;
  logic [DATA_BITS-1:0]            x_q;
  logic [31:0]                     out_q;
  logic                            out_vld_q;
  logic                            mode_q;
  logic [lrps_pkg::ORDER_W-1:0]    order_q;
  logic [lrps_pkg::SHIFT_W-1:0]    shift_q;

  logic                            in_beat, load_beat, sample_beat;
  logic [4:0]                      in_coef_index;
  logic [15:0]                     in_coef_value;
  logic [31:0]                     in_sample;
  logic [COEF_BITS-1:0]            coef_ld;
  logic [lrps_pkg::TAP_W-1:0]      taps;
  logic                            finish_go;

  lrps_pkg::cell_ctrl_t            cell_ctrl;
  lrps_pkg::mac_ctrl_t             mac_ctrl;
  logic [DATA_BITS-1:0]            hist_w [N_TAPS];
  logic [COEF_BITS-1:0]            coef_w [N_TAPS];
  logic [DATA_BITS-1:0]            ins_val;
  logic [ACC_W-1:0]                acc;

  logic signed [DATA_BITS-1:0]     x_s, y_s;
  logic signed [ACC_W-1:0]         x32, pred, y32;

  assign in_coef_index = s_axis_tdata[4:0];
  assign in_coef_value = s_axis_tdata[20:5];
  assign in_sample     = s_axis_tdata[52:21];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign load_beat     = in_beat && (s_axis_tuser[0] == lrps_pkg::OP_LOAD);
  assign sample_beat   = in_beat && (s_axis_tuser[0] == lrps_pkg::OP_SAMPLE);

  if (COEF_BITS <= 16) begin : g_coef_narrow
    assign coef_ld = in_coef_value[COEF_BITS-1:0];
  end else begin : g_coef_wide
    assign coef_ld = COEF_BITS'(in_coef_value);
  end

  // taps in use, capped at the chain length
  assign taps = (lrps_pkg::TAP_W'(order_q) > TAP_MAX) ? TAP_MAX
                                                       : lrps_pkg::TAP_W'(order_q);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= lrps_pkg::MODE_ANALYSIS;
      order_q <= '0;
      shift_q <= lrps_pkg::SHIFT_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lrps_pkg::REG_MODE:  mode_q  <= cfg_wdata_i[0];
        lrps_pkg::REG_ORDER: order_q <= cfg_wdata_i[lrps_pkg::ORDER_W-1:0];
        lrps_pkg::REG_SHIFT: shift_q <= cfg_wdata_i[lrps_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // output arithmetic
  assign x_s  = $signed(x_q);
  assign x32  = ACC_W'(x_s);
  assign pred = $signed(acc) >>> shift_q;
  assign y32  = (mode_q == lrps_pkg::MODE_SYNTHESIS) ? (x32 - pred) : (x32 + pred);
  assign y_s  = $signed(y32[DATA_BITS-1:0]);
  assign ins_val = (mode_q == lrps_pkg::MODE_SYNTHESIS) ? y32[DATA_BITS-1:0] : x_q;

  assign finish_go = (state_q == ST_FINISH) && (!out_vld_q || m_axis_tready);

  always_comb begin
    cell_ctrl.clear  = sample_beat && s_axis_tuser[1];
    cell_ctrl.rotate = (state_q == ST_MAC);
    cell_ctrl.insert = finish_go;
    mac_ctrl.init    = sample_beat;
    mac_ctrl.run     = (state_q == ST_MAC) || (state_q == ST_DRAIN);
    mac_ctrl.tap_en  = (state_q == ST_MAC) && (lrps_pkg::TAP_W'(cnt_q) < taps);
  end

  for (genvar k = 0; k < N_TAPS; k++) begin : g_cell
    localparam int NXT = (k + 1) % N_TAPS;
    logic [DATA_BITS-1:0] ins_h;
    logic                 load_k;

    if (k == 0) begin : g_head
      assign ins_h = ins_val;
    end else begin : g_body
      assign ins_h = hist_w[k-1];
    end

    assign load_k = load_beat && (int'(in_coef_index) == k);

    lrps_cell #(
      .COEF_BITS (COEF_BITS),
      .DATA_BITS (DATA_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (cell_ctrl),
      .load_i      (load_k),
      .load_coef_i (coef_ld),
      .rot_hist_i  (hist_w[NXT]),
      .rot_coef_i  (coef_w[NXT]),
      .ins_hist_i  (ins_h),
      .hist_o      (hist_w[k]),
      .coef_o      (coef_w[k])
    );
  end

  lrps_mac #(
    .COEF_BITS (COEF_BITS),
    .DATA_BITS (DATA_BITS)
  ) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mac_ctrl),
    .shift_i (shift_q),
    .coef_i  (coef_w[0]),
    .hist_i  (hist_w[0]),
    .acc_o   (acc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      x_q       <= '0;
      out_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (sample_beat) begin
            x_q     <= in_sample[DATA_BITS-1:0];
            cnt_q   <= '0;
            state_q <= ST_MAC;
          end
        end
        ST_MAC: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_LAST) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          if (finish_go) begin
            out_q     <= 32'(y_s);
            out_vld_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule

// ----- src/lrps_checker.sv -----
// ----------------------------------------------------------------------------
// lrps_checker
// port-level checks of the lpc prediction filter
// ----------------------------------------------------------------------------
module lrps_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  logic in_beat;
  assign in_beat = s_axis_tvalid && s_axis_tready;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // a sample beat closes the input while it is worked on
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && (s_axis_tuser[0] == lrps_pkg::OP_SAMPLE) |=> !s_axis_tready)
    else $error("input stayed open after a sample beat");

  // a load beat makes no result
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && (s_axis_tuser[0] == lrps_pkg::OP_LOAD) && !m_axis_tvalid
    |=> !m_axis_tvalid)
    else $error("result after a load beat");

  // a new result comes only as a sample finishes, reopening the input
  a_result_reopens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready && !$past(s_axis_tready))
    else $error("result without a finished sample");

endmodule

bind lpc_residual_predict_synthesize lrps_checker u_lrps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
